/* src/backlash_step_compensation_assert.svh */
`ifndef BACKLASH_STEP_COMPENSATION_ASSERT_SVH
`define BACKLASH_STEP_COMPENSATION_ASSERT_SVH

// Checked on every clock edge outside reset.
`define BSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BSC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/bsc_pkg.sv */
package bsc_pkg;

	localparam int AXES   = 4;
	localparam int POS_W  = 32;
	localparam int AMT_W  = 16;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [AMT_W-1:0]        amt_t;

	typedef enum logic [1:0] {
		REG_BL_X = 2'd0,
		REG_BL_Y = 2'd1,
		REG_BL_Z = 2'd2,
		REG_BL_E = 2'd3
	} reg_idx_t;

	// Control handed from the top level to each axis slice.
	typedef struct packed {
		logic step;
		amt_t amt;
	} axis_ctl_t;

endpackage

/* src/bsc_if.sv */
interface bsc_move_in_if;
	logic           valid;
	logic           ready;
	bsc_pkg::pos_t  cur_pos_x;
	bsc_pkg::pos_t  cur_pos_y;
	bsc_pkg::pos_t  cur_pos_z;
	bsc_pkg::pos_t  cur_pos_e;
	bsc_pkg::pos_t  dest_x;
	bsc_pkg::pos_t  dest_y;
	bsc_pkg::pos_t  dest_z;
	bsc_pkg::pos_t  dest_e;

	modport source (
		output valid, cur_pos_x, cur_pos_y, cur_pos_z, cur_pos_e,
		output dest_x, dest_y, dest_z, dest_e,
		input  ready
	);
	modport sink (
		input  valid, cur_pos_x, cur_pos_y, cur_pos_z, cur_pos_e,
		input  dest_x, dest_y, dest_z, dest_e,
		output ready
	);
endinterface

interface bsc_move_out_if;
	logic           valid;
	logic           ready;
	bsc_pkg::pos_t  new_pos_x;
	bsc_pkg::pos_t  new_pos_y;
	bsc_pkg::pos_t  new_pos_z;
	bsc_pkg::pos_t  new_pos_e;
	bsc_pkg::pos_t  shift_total_x;
	bsc_pkg::pos_t  shift_total_y;
	bsc_pkg::pos_t  shift_total_z;
	bsc_pkg::pos_t  shift_total_e;

	modport source (
		output valid, new_pos_x, new_pos_y, new_pos_z, new_pos_e,
		output shift_total_x, shift_total_y, shift_total_z, shift_total_e,
		input  ready
	);
	modport sink (
		input  valid, new_pos_x, new_pos_y, new_pos_z, new_pos_e,
		input  shift_total_x, shift_total_y, shift_total_z, shift_total_e,
		output ready
	);
endinterface

/* src/bsc_axis.sv */
module bsc_axis (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bsc_pkg::axis_ctl_t    ctl,
	input  bsc_pkg::pos_t         cur,
	input  bsc_pkg::pos_t         dst,
	output bsc_pkg::pos_t         new_pos,
	output bsc_pkg::pos_t         shift_total
);

	logic          dir_neg_q;
	bsc_pkg::pos_t acc_q;
	logic          moving;
	logic          neg;
	logic          apply;
	bsc_pkg::pos_t amt_ext;
	bsc_pkg::pos_t fix;

	assign moving  = (dst != cur);
	assign neg     = (dst < cur);
	assign apply   = moving && (neg ^ dir_neg_q) && (ctl.amt != '0);
	assign amt_ext = bsc_pkg::pos_t'({{(bsc_pkg::POS_W-bsc_pkg::AMT_W){1'b0}}, ctl.amt});
	// shift against the new direction: a negative move raises the position
	assign fix     = neg ? -amt_ext : amt_ext;

	assign new_pos     = apply ? (cur - fix) : cur;
	assign shift_total = apply ? (acc_q + fix) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_neg_q <= 1'b0;
			acc_q     <= '0;
		end else if (ctl.step) begin
			acc_q <= shift_total;
			// a standing axis keeps its remembered direction
			if (moving) begin
				dir_neg_q <= neg;
			end
		end
	end

endmodule

/* src/backlash_step_compensation.sv */
// A move passes through the input register, then the result register, before it is offered.
// Throughput: one move per cycle; a stalled result holds the input register.
// Reset clears the backlash registers, remembered directions (all positive),
// shift totals and both valid flags at once; no clearing pass follows.
module backlash_step_compensation (
	input  logic                         clk,
	input  logic                         arst_n,
	bsc_move_in_if.sink                  move,
	bsc_move_out_if.source               result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bsc_pkg::ADDR_W-1:0]   paddr,
	input  logic [bsc_pkg::DATA_W-1:0]   pwdata,
	output logic [bsc_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	localparam int AXES = bsc_pkg::AXES;

	bsc_pkg::amt_t      backlash_q [AXES];
	bsc_pkg::reg_idx_t  reg_idx;
	logic               cfg_wr;

	logic               valid_s1;
	bsc_pkg::pos_t      cur_s1 [AXES];
	bsc_pkg::pos_t      dst_s1 [AXES];
	logic               out_valid_q;
	bsc_pkg::pos_t      new_pos_q [AXES];
	bsc_pkg::pos_t      shift_q [AXES];

	bsc_pkg::pos_t      cur_in [AXES];
	bsc_pkg::pos_t      dst_in [AXES];
	bsc_pkg::pos_t      new_pos [AXES];
	bsc_pkg::pos_t      shift_total [AXES];
	logic               advance;
	logic               step;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = bsc_pkg::reg_idx_t'(paddr[bsc_pkg::ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				backlash_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			unique case (reg_idx)
				bsc_pkg::REG_BL_X: backlash_q[0] <= pwdata[bsc_pkg::AMT_W-1:0];
				bsc_pkg::REG_BL_Y: backlash_q[1] <= pwdata[bsc_pkg::AMT_W-1:0];
				bsc_pkg::REG_BL_Z: backlash_q[2] <= pwdata[bsc_pkg::AMT_W-1:0];
				bsc_pkg::REG_BL_E: backlash_q[3] <= pwdata[bsc_pkg::AMT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			bsc_pkg::REG_BL_X: prdata[bsc_pkg::AMT_W-1:0] = backlash_q[0];
			bsc_pkg::REG_BL_Y: prdata[bsc_pkg::AMT_W-1:0] = backlash_q[1];
			bsc_pkg::REG_BL_Z: prdata[bsc_pkg::AMT_W-1:0] = backlash_q[2];
			bsc_pkg::REG_BL_E: prdata[bsc_pkg::AMT_W-1:0] = backlash_q[3];
			default: prdata = '0;
		endcase
	end

	// pipeline control
	assign advance    = !out_valid_q || result.ready;
	assign step       = valid_s1 && advance;
	assign move.ready = !valid_s1 || advance;

	assign cur_in[0] = move.cur_pos_x;
	assign cur_in[1] = move.cur_pos_y;
	assign cur_in[2] = move.cur_pos_z;
	assign cur_in[3] = move.cur_pos_e;
	assign dst_in[0] = move.dest_x;
	assign dst_in[1] = move.dest_y;
	assign dst_in[2] = move.dest_z;
	assign dst_in[3] = move.dest_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (move.ready) begin
				valid_s1 <= move.valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move.valid && move.ready) begin
			for (int i = 0; i < AXES; i++) begin
				cur_s1[i] <= cur_in[i];
				dst_s1[i] <= dst_in[i];
			end
		end
		if (step) begin
			for (int i = 0; i < AXES; i++) begin
				new_pos_q[i] <= new_pos[i];
				shift_q[i]   <= shift_total[i];
			end
		end
	end

	for (genvar g = 0; g < AXES; g++) begin : g_axis
		bsc_pkg::axis_ctl_t ctl;

		assign ctl.step = step;
		assign ctl.amt  = backlash_q[g];

		bsc_axis u_axis (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.cur         (cur_s1[g]),
			.dst         (dst_s1[g]),
			.new_pos     (new_pos[g]),
			.shift_total (shift_total[g])
		);
	end

	assign result.valid         = out_valid_q;
	assign result.new_pos_x     = new_pos_q[0];
	assign result.new_pos_y     = new_pos_q[1];
	assign result.new_pos_z     = new_pos_q[2];
	assign result.new_pos_e     = new_pos_q[3];
	assign result.shift_total_x = shift_q[0];
	assign result.shift_total_y = shift_q[1];
	assign result.shift_total_z = shift_q[2];
	assign result.shift_total_e = shift_q[3];

endmodule

/* src/bsc_chk.sv */
`include "backlash_step_compensation_assert.svh"

module bsc_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input bsc_pkg::pos_t  new_pos_x,
	input bsc_pkg::pos_t  shift_total_x
);

	`BSC_ASSERT_ALWAYS(a_reset_no_result, !arst_n |-> !out_valid, "result offered in reset")

	`BSC_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(new_pos_x) && $stable(shift_total_x), "stalled result changed")

	`BSC_ASSERT(a_result_origin, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without input transfer two cycles before")

	`BSC_ASSERT(a_backpressure, !in_ready |-> out_valid && !out_ready, "input blocked while result side free")

endmodule

bind backlash_step_compensation bsc_chk u_bsc_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (move.valid),
	.in_ready      (move.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.new_pos_x     (result.new_pos_x),
	.shift_total_x (result.shift_total_x)
);

/* test/bsc_shift_checker.sv */
module bsc_shift_checker
	import bsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	bsc_move_in_if            mv_in,
	bsc_move_out_if           mv_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output int                mismatches,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_CAP = 30;

	typedef struct packed {
		pos_t [AXES-1:0] pos;
		pos_t [AXES-1:0] total;
	} shifted_move_t;

	string axis_tag [AXES] = '{"x", "y", "z", "e"};

	amt_t            backlash [AXES];
	logic [AXES-1:0] last_neg;
	pos_t            totals [AXES];
	shifted_move_t   awaited_moves [$];

	task automatic report(input string what);
		mismatches++;
		// keep counting past the cap, stop printing
		if (mismatches <= PRINT_CAP) begin
			$display("%0t bsc_shift_checker: %s", $time, what);
		end
	endtask

	function automatic shifted_move_t correct_move(input pos_t [AXES-1:0] cur,
	                                               input pos_t [AXES-1:0] dst);
		shifted_move_t    r;
		logic             neg;
		logic             moves;
		logic [POS_W-1:0] fix;
		int               a;
		for (a = 0; a < AXES; a++) begin
			r.pos[a] = cur[a];
			neg = $signed(dst[a]) < $signed(cur[a]);
			moves = dst[a] != cur[a];
			if (moves && neg != last_neg[a] && backlash[a] != '0) begin
				fix = POS_W'(backlash[a]);
				if (neg) begin
					fix = -fix;
				end
				// shift against the new direction
				r.pos[a] = cur[a] - fix;
				totals[a] = totals[a] + fix;
			end
			if (moves) begin
				last_neg[a] = neg;
			end
			r.total[a] = totals[a];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		shifted_move_t   got;
		shifted_move_t   want;
		pos_t [AXES-1:0] cur;
		pos_t [AXES-1:0] dst;
		int              a;
		if (!arst_n) begin
			for (a = 0; a < AXES; a++) begin
				backlash[a] = '0;
				totals[a] = '0;
			end
			last_neg = '0;
			awaited_moves.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (mv_out.valid && mv_out.ready) begin
				got.pos[0] = mv_out.new_pos_x;
				got.pos[1] = mv_out.new_pos_y;
				got.pos[2] = mv_out.new_pos_z;
				got.pos[3] = mv_out.new_pos_e;
				got.total[0] = mv_out.shift_total_x;
				got.total[1] = mv_out.shift_total_y;
				got.total[2] = mv_out.shift_total_z;
				got.total[3] = mv_out.shift_total_e;
				if (awaited_moves.size() == 0) begin
					report("result transfer with no move awaiting it");
				end else begin
					want = awaited_moves.pop_front();
					for (a = 0; a < AXES; a++) begin
						if (got.pos[a] !== want.pos[a]) begin
							report($sformatf("new_pos_%s: expected %0d, got %0d",
								axis_tag[a], $signed(want.pos[a]), $signed(got.pos[a])));
						end
						if (got.total[a] !== want.total[a]) begin
							report($sformatf("shift_total_%s: expected %0d, got %0d",
								axis_tag[a], $signed(want.total[a]), $signed(got.total[a])));
						end
					end
				end
			end
			if (mv_in.valid && mv_in.ready) begin
				cur[0] = mv_in.cur_pos_x;
				cur[1] = mv_in.cur_pos_y;
				cur[2] = mv_in.cur_pos_z;
				cur[3] = mv_in.cur_pos_e;
				dst[0] = mv_in.dest_x;
				dst[1] = mv_in.dest_y;
				dst[2] = mv_in.dest_z;
				dst[3] = mv_in.dest_e;
				awaited_moves.push_back(correct_move(cur, dst));
			end
			// only the low half of a write is kept
			if (psel && penable && pwrite && pready) begin
				backlash[paddr[ADDR_W-1:2]] = pwdata[AMT_W-1:0];
			end
			pending = awaited_moves.size();
		end
	end

endmodule

/* test/tb_backlash_step_compensation.sv */
module tb_backlash_step_compensation;
	timeunit 1ns;
	timeprecision 1ps;

	import bsc_pkg::*;

	localparam int   CYCLE_LIMIT   = 200000;
	localparam int   PHASE_MOVES   = 480;
	localparam int   HOLD_CYCLES   = 80;
	localparam pos_t POS_MAX       = 32'sh7FFF_FFFF;
	localparam pos_t POS_MIN       = 32'sh8000_0000;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int mismatches;
	int pending;
	int tx_idle;
	int rx_idle;
	int hold_reqs;
	int cycle_count;

	bsc_move_in_if  mv_in ();
	bsc_move_out_if mv_out ();

	backlash_step_compensation dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.move    (mv_in),
		.result  (mv_out),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	bsc_shift_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.mv_in      (mv_in),
		.mv_out     (mv_out),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_backlash_step_compensation: done, errors");
		$finish;
	end

	// result side: random stalls, or a long hold-off when one is requested
	initial begin : receiver
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		mv_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				mv_out.ready = 1'b0;
				hold_left--;
			end else begin
				mv_out.ready = $urandom_range(0, 99) >= rx_idle;
			end
		end
	end

	task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ADDR_W'({idx, 2'b00});
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic send_move(input pos_t [AXES-1:0] c, input pos_t [AXES-1:0] d);
		while ($urandom_range(0, 99) < tx_idle) begin
			mv_in.valid = 1'b0;
			@(negedge clk);
		end
		mv_in.valid = 1'b1;
		mv_in.cur_pos_x = c[0];
		mv_in.cur_pos_y = c[1];
		mv_in.cur_pos_z = c[2];
		mv_in.cur_pos_e = c[3];
		mv_in.dest_x = d[0];
		mv_in.dest_y = d[1];
		mv_in.dest_z = d[2];
		mv_in.dest_e = d[3];
		do @(posedge clk); while (!mv_in.ready);
		@(negedge clk);
	endtask

	task automatic send_same(input pos_t c, input pos_t d);
		send_move({AXES{c}}, {AXES{d}});
	endtask

	// hold the sender until every result is back
	task automatic drain();
		mv_in.valid = 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (3) @(negedge clk);
	endtask

	function automatic void random_move(output pos_t [AXES-1:0] c, output pos_t [AXES-1:0] d);
		int a;
		for (a = 0; a < AXES; a++) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					c[a] = $urandom;
					d[a] = c[a];
				end
				2, 3, 4, 5: begin
					// short hops around zero give frequent reversals
					c[a] = pos_t'($urandom_range(0, 2000)) - 1000;
					if ($urandom_range(0, 1)) begin
						d[a] = c[a] + pos_t'($urandom_range(1, 40));
					end else begin
						d[a] = c[a] - pos_t'($urandom_range(1, 40));
					end
				end
				default: begin
					c[a] = $urandom;
					d[a] = $urandom;
				end
			endcase
		end
	endfunction

	task automatic random_phase(input int count, input bit with_hold);
		pos_t [AXES-1:0] c;
		pos_t [AXES-1:0] d;
		int              i;
		for (i = 0; i < count; i++) begin
			if (with_hold && (i == 0 || i == count / 2)) begin
				hold_reqs++;
			end
			random_move(c, d);
			send_move(c, d);
		end
	endtask

	task automatic write_random_amounts();
		apb_write(REG_BL_X, $urandom);
		apb_write(REG_BL_Y, $urandom);
		apb_write(REG_BL_Z, $urandom);
		apb_write(REG_BL_E, $urandom);
	endtask

	initial begin
		pos_t [AXES-1:0] c;
		pos_t [AXES-1:0] d;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mv_in.valid = 1'b0;
		mv_in.cur_pos_x = '0;
		mv_in.cur_pos_y = '0;
		mv_in.cur_pos_z = '0;
		mv_in.cur_pos_e = '0;
		mv_in.dest_x = '0;
		mv_in.dest_y = '0;
		mv_in.dest_z = '0;
		mv_in.dest_e = '0;
		tx_idle = 35;
		rx_idle = 57;
		hold_reqs = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// zero amounts: reversals are remembered, nothing shifts
		send_same(0, 0);
		send_same(0, -5);
		send_same(-5, 10);
		send_same(10, 3);
		drain();

		apb_write(REG_BL_X, 32'hFFFF_FFFF);
		apb_write(REG_BL_Y, 32'h0000_0001);
		apb_write(REG_BL_Z, 32'h5A5A_8000);
		apb_write(REG_BL_E, 32'h0000_0000);

		send_same(POS_MAX, POS_MIN);
		send_same(POS_MIN, POS_MAX);
		send_same(0, 5);
		send_same(POS_MIN, POS_MIN);
		send_same(5, 0);
		send_same(POS_MAX, POS_MAX);
		send_same(-1, 0);
		send_same(0, -1);
		send_same(POS_MAX, POS_MAX - 1);
		send_same(POS_MIN, POS_MIN + 1);
		c[0] = 7;
		d[0] = 7;
		c[1] = 100;
		d[1] = 50;
		c[2] = -50;
		d[2] = -10;
		c[3] = 3;
		d[3] = -3;
		send_move(c, d);
		c[0] = 7;
		d[0] = -7;
		c[1] = 50;
		d[1] = 50;
		c[2] = -10;
		d[2] = -20;
		c[3] = -3;
		d[3] = 3;
		send_move(c, d);
		drain();

		write_random_amounts();
		random_phase(PHASE_MOVES, 1'b0);
		drain();

		tx_idle = 57;
		rx_idle = 35;
		apb_write(REG_BL_X, 32'h0000_FFFF);
		apb_write(REG_BL_Y, 32'h0000_0001);
		apb_write(REG_BL_Z, 32'h0000_0000);
		apb_write(REG_BL_E, 32'hFFFF_FFFF);
		random_phase(PHASE_MOVES, 1'b0);
		drain();

		// no idling; the receiver holds off while moves keep coming
		tx_idle = 0;
		rx_idle = 0;
		write_random_amounts();
		random_phase(PHASE_MOVES, 1'b1);
		drain();

		repeat (10) @(negedge clk);
		if (mismatches == 0) begin
			$display("tb_backlash_step_compensation: done, clean");
		end else begin
			$display("tb_backlash_step_compensation: done, errors");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/bsc_pkg.sv
src/bsc_if.sv
src/bsc_axis.sv
src/backlash_step_compensation.sv
src/bsc_chk.sv
test/bsc_shift_checker.sv
test/tb_backlash_step_compensation.sv
